// ===== rtl/html_entity_name_decoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// HTML entity name decoder assertion macros
// Shared concurrent assertion forms; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef HTML_ENTITY_NAME_DECODER_UNIT_ASSERT_SVH
`define HTML_ENTITY_NAME_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define HEND_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: condition must never hold");

`define HEND_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: expected next-cycle result missing");

`else

`define HEND_ASSERT_NEVER(label, clk, rst, cond)

`define HEND_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/hend_pkg.sv =====
// ----------------------------------------------------------------------------
// HTML entity name decoder package
// Shared types, sizes and the Latin-1 entity name ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package hend_pkg;

  localparam int DEF_SCAN_LIMIT = 63;
  localparam int DEF_NAME_KEEP  = 6;
  localparam int ROM_NAME_W     = 48;
  localparam int CONS_W         = 7;
  localparam int QUEUE_DEPTH    = 2;
  localparam int ENT_COUNT      = 92;
  localparam logic [7:0] SEMI_CHAR = 8'h3B;

  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_LIMIT  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_MATCH   = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_LIMIT   = 2'd2
  } status_t;

  localparam logic [ROM_NAME_W-1:0] ENT_TXT [ENT_COUNT] = '{
    "quot", "apos", "iexcl", "cent",
    "pound", "yen", "brvbar", "sect",
    "copy", "laquo", "raquo", "not",
    "reg", "deg", "plusmn", "sup2",
    "sup3", "micro", "para", "sup1",
    "middot", "frac14", "frac12", "iquest",
    "frac34", "AElig", "Aacute", "Acirc",
    "Agrave", "Aring", "Atilde", "Auml",
    "Ccedil", "ETH", "Eacute", "Ecirc",
    "Egrave", "Euml", "Iacute", "Icirc",
    "Igrave", "Iuml", "Ntilde", "Oacute",
    "Ocirc", "Ograve", "Oslash", "Otilde",
    "Ouml", "THORN", "Uacute", "Ucirc",
    "Ugrave", "Uuml", "Yacute", "aacute",
    "acirc", "aelig", "agrave", "amp",
    "aring", "atilde", "auml", "ccedil",
    "eacute", "ecirc", "egrave", "eth",
    "euml", "tagc", "gt", "iacute",
    "icirc", "igrave", "iuml", "stago",
    "lt", "ntilde", "oacute", "ocirc",
    "ograve", "oslash", "otilde", "ouml",
    "szlig", "thorn", "uacute", "ucirc",
    "ugrave", "uuml", "yacute", "yuml"
  };

  localparam logic [2:0] ENT_LEN [ENT_COUNT] = '{
    3'd4, 3'd4, 3'd5, 3'd4,
    3'd5, 3'd3, 3'd6, 3'd4,
    3'd4, 3'd5, 3'd5, 3'd3,
    3'd3, 3'd3, 3'd6, 3'd4,
    3'd4, 3'd5, 3'd4, 3'd4,
    3'd6, 3'd6, 3'd6, 3'd6,
    3'd6, 3'd5, 3'd6, 3'd5,
    3'd6, 3'd5, 3'd6, 3'd4,
    3'd6, 3'd3, 3'd6, 3'd5,
    3'd6, 3'd4, 3'd6, 3'd5,
    3'd6, 3'd4, 3'd6, 3'd6,
    3'd5, 3'd6, 3'd6, 3'd6,
    3'd4, 3'd5, 3'd6, 3'd5,
    3'd6, 3'd4, 3'd6, 3'd6,
    3'd5, 3'd5, 3'd6, 3'd3,
    3'd5, 3'd6, 3'd4, 3'd6,
    3'd6, 3'd5, 3'd6, 3'd3,
    3'd4, 3'd4, 3'd2, 3'd6,
    3'd5, 3'd6, 3'd4, 3'd5,
    3'd2, 3'd6, 3'd6, 3'd5,
    3'd6, 3'd6, 3'd6, 3'd4,
    3'd5, 3'd5, 3'd6, 3'd5,
    3'd6, 3'd4, 3'd6, 3'd4
  };

  localparam logic [7:0] ENT_CODE [ENT_COUNT] = '{
    8'd34,  8'd39,  8'd161, 8'd162,
    8'd163, 8'd165, 8'd166, 8'd167,
    8'd169, 8'd171, 8'd187, 8'd172,
    8'd174, 8'd176, 8'd177, 8'd178,
    8'd179, 8'd181, 8'd182, 8'd185,
    8'd183, 8'd188, 8'd189, 8'd191,
    8'd190, 8'd198, 8'd193, 8'd194,
    8'd192, 8'd197, 8'd195, 8'd196,
    8'd199, 8'd208, 8'd201, 8'd202,
    8'd200, 8'd203, 8'd205, 8'd206,
    8'd204, 8'd207, 8'd209, 8'd211,
    8'd212, 8'd210, 8'd216, 8'd213,
    8'd214, 8'd222, 8'd218, 8'd219,
    8'd217, 8'd220, 8'd221, 8'd225,
    8'd226, 8'd230, 8'd224, 8'd38,
    8'd229, 8'd227, 8'd228, 8'd231,
    8'd233, 8'd234, 8'd232, 8'd240,
    8'd235, 8'd62,  8'd62,  8'd237,
    8'd238, 8'd236, 8'd239, 8'd60,
    8'd60,  8'd241, 8'd243, 8'd244,
    8'd242, 8'd248, 8'd245, 8'd246,
    8'd223, 8'd254, 8'd250, 8'd251,
    8'd249, 8'd252, 8'd253, 8'd255
  };

  // Reorder a right-justified string so that its first byte sits at the low end.
  function automatic logic [ROM_NAME_W-1:0] first_byte_low(
    input logic [ROM_NAME_W-1:0] txt,
    input logic [2:0]            len
  );
    logic [ROM_NAME_W-1:0] res;
    int                    n;
    res = '0;
    n   = int'(len);
    for (int k = 0; k < ROM_NAME_W / 8; k++) begin
      if (k < n) begin
        res[8*k +: 8] = txt[8*(n-1-k) +: 8];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hend_front.sv =====
// ----------------------------------------------------------------------------
// HTML entity name decoder front end
// Accepts bytes, tracks the scan and queues lookups and limit results.
// ----------------------------------------------------------------------------
`default_nettype none

module hend_front
  import hend_pkg::*;
#(
  parameter int SCAN_LIMIT = DEF_SCAN_LIMIT,
  parameter int NAME_KEEP  = DEF_NAME_KEEP,
  localparam int NW = 8 * NAME_KEEP,
  localparam int LW = $clog2(NAME_KEEP + 2),
  localparam int CW = $clog2(SCAN_LIMIT + 1),
  localparam int EW = 1 + NW + LW + CW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          start_req,
  input  wire logic [7:0]    ch,
  input  wire logic          q_full,
  output logic               push,
  output logic [EW-1:0]      push_data
);

  logic          scanning;
  logic [NW-1:0] name_chars;
  logic [LW-1:0] name_len;
  logic [CW-1:0] scan_count;
  logic          name_ended;

  logic          take;
  logic          scan_e;
  logic [NW-1:0] name_e;
  logic [LW-1:0] len_e;
  logic [CW-1:0] cnt_e;
  logic          ended_e;
  logic [NW-1:0] name_next;
  logic [LW-1:0] len_next;
  logic [CW-1:0] cnt_next;
  logic          ended_next;
  logic          is_semi;
  logic          limit_hit;
  kind_t         kind;

  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;
  assign scan_e   = start_req || scanning;
  assign name_e   = start_req ? '0 : name_chars;
  assign len_e    = start_req ? '0 : name_len;
  assign cnt_e    = start_req ? '0 : scan_count;
  assign ended_e  = start_req ? 1'b0 : name_ended;
  assign is_semi  = (ch == SEMI_CHAR);

  always_comb begin
    name_next  = name_e;
    len_next   = len_e;
    ended_next = ended_e;
    cnt_next   = cnt_e + CW'(1);
    if (!ended_e) begin
      if (ch == 8'd0) begin
        ended_next = 1'b1;
      end else if (len_e < LW'(NAME_KEEP)) begin
        name_next[8*len_e +: 8] = ch;
        len_next                = len_e + LW'(1);
      end else begin
        len_next = LW'(NAME_KEEP + 1);
      end
    end
  end

  assign limit_hit = (cnt_next == CW'(SCAN_LIMIT));
  assign push      = take && scan_e && (is_semi || limit_hit);
  assign kind      = is_semi ? KIND_LOOKUP : KIND_LIMIT;
  assign push_data = {kind, name_e, len_e, cnt_e};

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning   <= 1'b0;
      name_chars <= '0;
      name_len   <= '0;
      scan_count <= '0;
      name_ended <= 1'b0;
    end else if (take && scan_e) begin
      if (is_semi) begin
        scanning <= 1'b0;
      end else begin
        scanning   <= !limit_hit;
        name_chars <= name_next;
        name_len   <= len_next;
        scan_count <= cnt_next;
        name_ended <= ended_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hend_queue.sv =====
// ----------------------------------------------------------------------------
// HTML entity name decoder queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "html_entity_name_decoder_unit_assert.svh"

module hend_queue
  import hend_pkg::*;
#(
  parameter int WIDTH = 8,
  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int QCW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  output logic                  q_valid,
  output logic [WIDTH-1:0]      q_data,
  input  wire logic             pop
);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;

  assign full    = (count == QCW'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

  `HEND_ASSERT_NEVER(a_push_full, clk, rst, push && full && !pop)
  `HEND_ASSERT_NEVER(a_pop_empty, clk, rst, pop && !q_valid)
  `HEND_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == QCW'($past(count) + 1'b1))

endmodule

`default_nettype wire

// ===== rtl/hend_back.sv =====
// ----------------------------------------------------------------------------
// HTML entity name decoder back end
// Matches queued names against the entity ROM and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hend_back
  import hend_pkg::*;
#(
  parameter int SCAN_LIMIT = DEF_SCAN_LIMIT,
  parameter int NAME_KEEP  = DEF_NAME_KEEP,
  localparam int NW = 8 * NAME_KEEP,
  localparam int LW = $clog2(NAME_KEEP + 2),
  localparam int CW = $clog2(SCAN_LIMIT + 1),
  localparam int EW = 1 + NW + LW + CW
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire logic [EW-1:0]     q_data,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             char_code,
  output logic [CONS_W-1:0]      consumed_len,
  output logic [1:0]             status
);

  kind_t                 kind;
  logic [NW-1:0]         name;
  logic [LW-1:0]         len;
  logic [CW-1:0]         cnt;
  logic                  hit;
  logic [7:0]            code;
  logic                  load;
  status_t               status_reg;

  assign kind = kind_t'(q_data[EW-1]);
  assign name = q_data[EW-2 -: NW];
  assign len  = q_data[LW+CW-1 -: LW];
  assign cnt  = q_data[CW-1:0];

  always_comb begin
    hit  = 1'b0;
    code = 8'd0;
    for (int r = 0; r < ENT_COUNT; r++) begin
      if ((len == LW'(ENT_LEN[r])) &&
          (name[ROM_NAME_W-1:0] == first_byte_low(ENT_TXT[r], ENT_LEN[r]))) begin
        hit  = 1'b1;
        code = code | ENT_CODE[r];
      end
    end
  end

  assign load = q_valid && (!out_valid || !out_stall);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (kind == KIND_LIMIT) begin
        char_code    <= 8'd0;
        consumed_len <= '0;
        status_reg   <= ST_LIMIT;
      end else begin
        char_code    <= hit ? code : 8'd0;
        consumed_len <= CONS_W'(cnt) + CONS_W'(2);
        status_reg   <= hit ? ST_MATCH : ST_UNKNOWN;
      end
    end
  end

  assign status = status_reg;

endmodule

`default_nettype wire

// ===== rtl/html_entity_name_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// HTML entity name decoder
// Decodes Latin-1 named character references one byte per beat.
//
// Input channel: in_valid/in_stall with start_req and ch. Raise start_req on
// the first byte after the ampersand. Bytes with no scan running are dropped.
// Output channel: out_valid/out_stall with char_code, consumed_len, status.
// A beat leaves on a semicolon (status matched or unknown, consumed_len is
// the count of bytes scanned before it plus two) or when SCAN_LIMIT bytes pass
// without one (status limit, other fields zero).
// The byte ending the scan is written into the queue, and the back end then
// registers it into the output beat and raises out_valid. Throughput: one byte
// per cycle; the front end only stalls when the two-entry queue ahead of the
// ROM compare is full. When out_stall is high the result beat holds; the queue
// absorbs up to two more results before in_stall rises.
// Reset clears the scan, the queue and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module html_entity_name_decoder_unit
  import hend_pkg::*;
#(
  parameter int SCAN_LIMIT = DEF_SCAN_LIMIT,
  parameter int NAME_KEEP  = DEF_NAME_KEEP
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              start_req,
  input  wire logic [7:0]        ch,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             char_code,
  output logic [CONS_W-1:0]      consumed_len,
  output logic [1:0]             status
);

  localparam int EW = 1 + 8 * NAME_KEEP + $clog2(NAME_KEEP + 2) + $clog2(SCAN_LIMIT + 1);

  logic          q_full;
  logic          push;
  logic [EW-1:0] push_data;
  logic          q_valid;
  logic [EW-1:0] q_data;
  logic          pop;

  hend_front #(
    .SCAN_LIMIT (SCAN_LIMIT),
    .NAME_KEEP  (NAME_KEEP)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .start_req (start_req),
    .ch        (ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  hend_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop)
  );

  hend_back #(
    .SCAN_LIMIT (SCAN_LIMIT),
    .NAME_KEEP  (NAME_KEEP)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .char_code    (char_code),
    .consumed_len (consumed_len),
    .status       (status)
  );

endmodule

`default_nettype wire
